// File: sv/bmhq_pkg.sv
// Shared types and codes for the binary min-heap queue.
package bmhq_pkg;

   localparam int KeyWidth   = 32;
   localparam int CountWidth = 7;

   typedef logic signed [KeyWidth-1:0] key_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_EMPTY      = 2'd2,
      STATUS_RESERVED   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_LAST,
      ST_DN_RD,
      ST_DN_CMP
   } state_type;

endpackage

// File: sv/binary_min_heap_queue.sv
// Binary min-heap priority queue: top level with heap store and sift sequencer.
//
// Usage: raise start with req_opcode/req_value; the word is taken at the edge
// where start is high and busy is low. OP_INSERT adds req_value, OP_REMOVE
// takes out the smallest key. Every accepted word produces exactly one
// response word, shown for a single cycle with rsp_strobe high: the key
// removed (zero for an insert), the new minimum (zero when empty), the entry
// count and a status. The receiver cannot hold responses off.
//
// Timing: a rejected word (insert when full, remove when empty) answers on
// the next cycle and busy never rises. An insert walks up, a remove walks
// down; each level takes a registered memory read and a compare/write
// through the shared key comparator. At the default depth an insert moves
// at most 6 levels and a remove at most 5. busy rises at the accepting edge
// and falls as the response shows; the next word is taken at the end of the
// response cycle. Reset (synchronous, active high) empties the queue; the
// store is not cleared, only entries below the count are read.
module binary_min_heap_queue #(
   parameter int CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic signed [31:0]                req_value,
   output logic                              rsp_strobe,
   output logic signed [31:0]                rsp_removed_value,
   output logic signed [31:0]                rsp_top_value,
   output logic [6:0]                        rsp_entry_count,
   output logic [1:0]                        rsp_status
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // slot address
   localparam int CW = $clog2(CAPACITY + 1);                     // entry count
   localparam int IW = AW + 2;                                   // child index

   // heap store: one write port, two registered read ports
   bmhq_pkg::key_type mem [CAPACITY];
   bmhq_pkg::key_type rd_a_ff;
   bmhq_pkg::key_type rd_b_ff;
   logic [AW-1:0]     rd_a_addr;
   logic [AW-1:0]     rd_b_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   bmhq_pkg::key_type wr_data;

   // control and datapath registers
   bmhq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       pos_ff, pos_in;
   bmhq_pkg::key_type   cur_ff, cur_in;        // key being sifted
   bmhq_pkg::key_type   root_ff, root_in;      // copy of slot 0
   bmhq_pkg::key_type   removed_ff, removed_in;
   logic                is_remove_ff, is_remove_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   bmhq_pkg::key_type   rsp_removed_ff, rsp_removed_in;
   bmhq_pkg::key_type   rsp_top_ff, rsp_top_in;
   logic [6:0]          rsp_count_ff, rsp_count_in;
   bmhq_pkg::status_type rsp_status_ff, rsp_status_in;

   // index arithmetic
   logic [IW-1:0] n_ext;
   logic [IW-1:0] left_idx;
   logic [IW-1:0] right_idx;
   logic          left_ok;
   logic          right_ok;
   logic [AW-1:0] parent_idx;
   logic [31:0]   count_wide;

   // decisions
   logic              accept;
   logic              acc_insert;
   logic              acc_remove;
   logic              reject_full;
   logic              reject_empty;
   logic              up_at_root;
   logic              up_move;
   logic              dn_empty;
   logic              dn_leaf;
   logic              pick_right;
   bmhq_pkg::key_type best_val;
   logic [IW-1:0]     best_idx;
   logic              dn_move;
   logic              finish;
   bmhq_pkg::key_type cmp_lhs;
   bmhq_pkg::key_type cmp_rhs;
   logic              key_less;

   assign n_ext      = IW'(count_ff);
   assign left_idx   = (IW'(pos_ff) << 1) + IW'(1);
   assign right_idx  = left_idx + IW'(1);
   assign left_ok    = left_idx < n_ext;
   assign right_ok   = right_idx < n_ext;
   assign parent_idx = (pos_ff - AW'(1)) >> 1;

   assign accept       = start && (state_ff == bmhq_pkg::ST_IDLE);
   assign acc_insert   = accept && (req_opcode == bmhq_pkg::OP_INSERT);
   assign acc_remove   = accept && (req_opcode == bmhq_pkg::OP_REMOVE);
   assign reject_full  = acc_insert && (count_ff == CW'(CAPACITY));
   assign reject_empty = acc_remove && (count_ff == '0);

   // one comparator serves both walks: hole key against parent going up,
   // best child against hole key going down
   assign cmp_lhs  = (state_ff == bmhq_pkg::ST_DN_CMP) ? best_val : cur_ff;
   assign cmp_rhs  = (state_ff == bmhq_pkg::ST_DN_CMP) ? cur_ff : rd_a_ff;
   assign key_less = cmp_lhs < cmp_rhs;

   assign up_at_root = (pos_ff == '0);
   assign up_move    = key_less;                           // parent read in rd_a
   assign dn_empty   = (count_ff == '0);
   assign dn_leaf    = !left_ok;
   // left child wins a tie between the two children
   assign pick_right = right_ok && (rd_b_ff < rd_a_ff);
   assign best_val   = pick_right ? rd_b_ff : rd_a_ff;
   assign best_idx   = pick_right ? right_idx : left_idx;
   assign dn_move    = key_less;

   always_comb begin
      finish = 1'b0;
      case (state_ff)
         bmhq_pkg::ST_UP_RD:   finish = up_at_root;
         bmhq_pkg::ST_UP_CMP:  finish = !up_move;
         bmhq_pkg::ST_DN_LAST: finish = dn_empty;
         bmhq_pkg::ST_DN_RD:   finish = dn_leaf;
         bmhq_pkg::ST_DN_CMP:  finish = !dn_move;
         default:              finish = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmhq_pkg::ST_IDLE: begin
            if (acc_insert && !reject_full) begin
               state_in = bmhq_pkg::ST_UP_RD;
            end else if (acc_remove && !reject_empty) begin
               state_in = bmhq_pkg::ST_DN_LAST;
            end
         end
         bmhq_pkg::ST_UP_RD: begin
            state_in = up_at_root ? bmhq_pkg::ST_IDLE : bmhq_pkg::ST_UP_CMP;
         end
         bmhq_pkg::ST_UP_CMP: begin
            state_in = up_move ? bmhq_pkg::ST_UP_RD : bmhq_pkg::ST_IDLE;
         end
         bmhq_pkg::ST_DN_LAST: begin
            state_in = dn_empty ? bmhq_pkg::ST_IDLE : bmhq_pkg::ST_DN_RD;
         end
         bmhq_pkg::ST_DN_RD: begin
            state_in = dn_leaf ? bmhq_pkg::ST_IDLE : bmhq_pkg::ST_DN_CMP;
         end
         bmhq_pkg::ST_DN_CMP: begin
            state_in = dn_move ? bmhq_pkg::ST_DN_RD : bmhq_pkg::ST_IDLE;
         end
         default: state_in = bmhq_pkg::ST_IDLE;
      endcase
   end

   // datapath, memory ports and response
   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      removed_in   = removed_ff;
      is_remove_in = is_remove_ff;
      rd_a_addr    = '0;
      rd_b_addr    = '0;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cur_ff;

      case (state_ff)
         bmhq_pkg::ST_IDLE: begin
            if (acc_insert && !reject_full) begin
               // hole opens at the end of the array
               pos_in       = AW'(count_ff);
               cur_in       = req_value;
               count_in     = count_ff + CW'(1);
               is_remove_in = 1'b0;
            end else if (acc_remove && !reject_empty) begin
               removed_in   = root_ff;
               count_in     = count_ff - CW'(1);
               rd_a_addr    = AW'(count_ff - CW'(1));   // fetch last entry
               is_remove_in = 1'b1;
            end
         end
         bmhq_pkg::ST_UP_RD: begin
            if (up_at_root) begin
               wr_en = 1'b1;
            end else begin
               rd_a_addr = parent_idx;
            end
         end
         bmhq_pkg::ST_UP_CMP: begin
            wr_en = 1'b1;
            if (up_move) begin
               wr_data = rd_a_ff;                   // parent drops into the hole
               pos_in  = parent_idx;
            end
         end
         bmhq_pkg::ST_DN_LAST: begin
            cur_in = rd_a_ff;
            pos_in = '0;
         end
         bmhq_pkg::ST_DN_RD: begin
            if (dn_leaf) begin
               wr_en = 1'b1;
            end else begin
               rd_a_addr = left_idx[AW-1:0];
               rd_b_addr = right_idx[AW-1:0];
            end
         end
         bmhq_pkg::ST_DN_CMP: begin
            wr_en = 1'b1;
            if (dn_move) begin
               wr_data = best_val;                  // child rises into the hole
               pos_in  = best_idx[AW-1:0];
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      root_in = root_ff;
      if (wr_en && (wr_addr == '0)) begin
         root_in = wr_data;
      end
   end

   assign count_wide = 32'(count_ff);

   // response word
   always_comb begin
      rsp_strobe_in  = 1'b0;
      rsp_removed_in = '0;
      rsp_top_in     = (count_ff != '0) ? root_in : '0;
      rsp_count_in   = count_wide[6:0];
      rsp_status_in  = bmhq_pkg::STATUS_OK;
      if (reject_full) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = bmhq_pkg::STATUS_FULL;
      end else if (reject_empty) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = bmhq_pkg::STATUS_EMPTY;
      end else if (finish) begin
         rsp_strobe_in  = 1'b1;
         rsp_removed_in = is_remove_ff ? removed_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bmhq_pkg::ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      root_ff        <= root_in;
      removed_ff     <= removed_in;
      is_remove_ff   <= is_remove_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_top_ff     <= rsp_top_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign busy              = (state_ff != bmhq_pkg::ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_top_value     = rsp_top_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

   // count never runs past the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // a full insert is answered next cycle with the full status, no walk
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      reject_full |=> (rsp_strobe && rsp_status == bmhq_pkg::STATUS_FULL && !busy))
      else $error("full insert not rejected");

   // every walk ends with a response word
   a_walk_response: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("sift ended without response");

   // hole stays inside the live entries while sifting
   a_hole_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmhq_pkg::ST_UP_CMP || state_ff == bmhq_pkg::ST_DN_CMP)
         |-> (CW'(pos_ff) < count_ff))
      else $error("sift position outside heap");

endmodule

// File: bench/binary_min_heap_queue_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the binary min-heap queue against a shadow heap.
module binary_min_heap_queue_test;

   localparam int Depth       = 64;
   localparam int RandomWords = 400;
   localparam int DrainCycles = 20;

   // One request word waiting to be offered, with the sender's idle odds
   // for the phase it belongs to.
   typedef struct {
      bmhq_pkg::opcode_type opcode;
      bmhq_pkg::key_type    key;
      int unsigned          gap_pct;
   } heap_request_type;

   // One response word as the shadow heap predicts it.
   typedef struct {
      bmhq_pkg::key_type               removed;
      bmhq_pkg::key_type               top;
      logic [bmhq_pkg::CountWidth-1:0] count;
      bmhq_pkg::status_type            status;
   } heap_response_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  start      = 1'b0;
   logic                  req_opcode = 1'b0;
   logic signed [31:0]    req_value  = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic signed [31:0]    rsp_removed_value;
   logic signed [31:0]    rsp_top_value;
   logic [6:0]            rsp_entry_count;
   logic [1:0]            rsp_status;

   heap_request_type  request_backlog [$];  // filled at time zero, drained by the driver
   heap_response_type response_queue  [$];  // predictions, oldest first
   heap_request_type  offered;              // word currently on the request ports
   heap_response_type want;
   int unsigned       words_total    = 0;
   int unsigned       words_accepted = 0;
   int unsigned       gap_pct_now    = 0;
   bit                mismatch_seen  = 1'b0;

   // Shadow heap: same array layout as the block, slot i has children 2i+1, 2i+2.
   bmhq_pkg::key_type shadow_keys [Depth];
   int unsigned       shadow_fill = 0;

   binary_min_heap_queue #(
      .CAPACITY(Depth)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_removed_value (rsp_removed_value),
      .rsp_top_value     (rsp_top_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status)
   );

   always #2 clock = ~clock;

   function automatic void shadow_swap(int unsigned a, int unsigned b);
      bmhq_pkg::key_type held;
      held           = shadow_keys[a];
      shadow_keys[a] = shadow_keys[b];
      shadow_keys[b] = held;
   endfunction

   // Applies one accepted word to the shadow heap and returns the response.
   // Only strictly smaller keys move, so equal keys stop a sift; on the way
   // down the left child wins a tie between the two children.
   function automatic heap_response_type heap_apply(bmhq_pkg::opcode_type op,
                                                    bmhq_pkg::key_type key);
      heap_response_type ans;
      int unsigned       pos;
      int unsigned       up;
      int unsigned       lft;
      int unsigned       rgt;
      int unsigned       best;
      ans.removed = '0;
      ans.status  = bmhq_pkg::STATUS_OK;
      if (op == bmhq_pkg::OP_INSERT) begin
         if (shadow_fill >= Depth) begin
            ans.status = bmhq_pkg::STATUS_FULL;      // full: store left untouched
         end else begin
            pos              = shadow_fill;
            shadow_keys[pos] = key;
            shadow_fill++;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!(shadow_keys[pos] < shadow_keys[up]))
                  break;
               shadow_swap(pos, up);
               pos = up;
            end
         end
      end else if (shadow_fill == 0) begin
         ans.status = bmhq_pkg::STATUS_EMPTY;        // empty: nothing changes
      end else begin
         ans.removed = shadow_keys[0];
         shadow_fill--;
         shadow_keys[0] = shadow_keys[shadow_fill];
         pos = 0;
         while (pos < shadow_fill) begin
            lft  = 2 * pos + 1;
            rgt  = 2 * pos + 2;
            best = pos;
            if (lft < shadow_fill && shadow_keys[lft] < shadow_keys[best])
               best = lft;
            if (rgt < shadow_fill && shadow_keys[rgt] < shadow_keys[best])
               best = rgt;
            if (best == pos)
               break;
            shadow_swap(pos, best);
            pos = best;
         end
      end
      ans.top   = (shadow_fill > 0) ? shadow_keys[0] : bmhq_pkg::key_type'(0);
      ans.count = bmhq_pkg::CountWidth'(shadow_fill);
      return ans;
   endfunction

   // Mostly a narrow band so ties and equal keys are common, then full-range
   // keys so every bit toggles, and now and then the signed extremes.
   function automatic bmhq_pkg::key_type pick_key();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 5)
         return bmhq_pkg::key_type'($urandom_range(15)) - bmhq_pkg::key_type'(8);
      else if (roll < 8)
         return bmhq_pkg::key_type'($urandom);
      else if (roll == 8)
         return $urandom_range(1) ? bmhq_pkg::key_type'(32'h7fff_ffff)
                                  : bmhq_pkg::key_type'(32'h8000_0000);
      else
         return $urandom_range(1)
                   ? bmhq_pkg::key_type'(32'h7fff_fff0 + $urandom_range(15))
                   : bmhq_pkg::key_type'(32'h8000_0000 + $urandom_range(15));
   endfunction

   task automatic queue_word(bmhq_pkg::opcode_type op, bmhq_pkg::key_type key);
      heap_request_type item;
      item.opcode  = op;
      item.key     = key;
      item.gap_pct = gap_pct_now;
      request_backlog.insert(request_backlog.size(), item);
   endtask

   // Driver: records the word taken at this edge, then offers the next one.
   // start stays high across back-to-back words, so it gets one assignment
   // per edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            response_queue.insert(response_queue.size(),
                                  heap_apply(offered.opcode, offered.key));
            words_accepted++;
         end
         if (!start || !busy) begin
            if (request_backlog.size() != 0 &&
                $urandom_range(99) >= request_backlog[0].gap_pct) begin
               offered    = request_backlog.pop_front();
               start      <= 1'b1;
               req_opcode <= offered.opcode;
               req_value  <= offered.key;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: the strobe lasts one cycle and cannot be held off, so every
   // strobed word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (response_queue.size() == 0) begin
            $display({"%0t: response word with nothing outstanding: ",
                      "removed %0d top %0d count %0d status %0d"},
                     $time, rsp_removed_value, rsp_top_value, rsp_entry_count,
                     rsp_status);
            mismatch_seen = 1'b1;
         end else begin
            want = response_queue.pop_front();
            if (rsp_removed_value !== want.removed) begin
               $display("%0t: removed_value mismatch: expected %0d actual %0d",
                        $time, want.removed, rsp_removed_value);
               mismatch_seen = 1'b1;
            end
            if (rsp_top_value !== want.top) begin
               $display("%0t: top_value mismatch: expected %0d actual %0d",
                        $time, want.top, rsp_top_value);
               mismatch_seen = 1'b1;
            end
            if (rsp_entry_count !== want.count) begin
               $display("%0t: entry_count mismatch: expected %0d actual %0d",
                        $time, want.count, rsp_entry_count);
               mismatch_seen = 1'b1;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_status);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   initial begin
      int unsigned episode;
      int unsigned kind;
      int unsigned run;
      int unsigned random_words;
      episode      = 0;
      random_words = 0;

      // Directed words: remove on empty, key extremes, equal keys, full drain.
      gap_pct_now = 11;
      queue_word(bmhq_pkg::OP_REMOVE, bmhq_pkg::key_type'($urandom));
      queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::key_type'(0));
      queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::key_type'(32'h7fff_ffff));
      queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::key_type'(32'h8000_0000));
      queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::key_type'(-1));
      queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::key_type'(5));
      queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::key_type'(5));
      queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::key_type'(-1));
      queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::key_type'(32'h8000_0000));
      repeat (9)
         queue_word(bmhq_pkg::OP_REMOVE, bmhq_pkg::key_type'($urandom));

      // Random part in episodes: insert runs, remove runs and mixed runs.
      // The first two push past full and past empty so both rejects show up
      // early; later runs hit them again at random.
      while (random_words < RandomWords) begin
         if (episode == 0) begin
            kind = 0;
            run  = Depth + 6;
         end else if (episode == 1) begin
            kind = 1;
            run  = Depth + 6;
         end else begin
            kind = $urandom_range(2);
            run  = (kind == 2) ? $urandom_range(4, 24) : $urandom_range(8, Depth + 8);
         end
         for (int i = 0; i < run && random_words < RandomWords; i++) begin
            // sender idle odds: 11 in 100, then 53 in 100, then none
            if (random_words < RandomWords / 3)
               gap_pct_now = 11;
            else if (random_words < 2 * RandomWords / 3)
               gap_pct_now = 53;
            else
               gap_pct_now = 0;
            case (kind)
               0: queue_word(bmhq_pkg::OP_INSERT, pick_key());
               1: queue_word(bmhq_pkg::OP_REMOVE, bmhq_pkg::key_type'($urandom));
               default: queue_word(bmhq_pkg::opcode_type'($urandom_range(1)), pick_key());
            endcase
            random_words++;
         end
         episode++;
      end
      words_total = request_backlog.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (words_accepted == words_total);
      while (response_queue.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);   // catch any stray strobe
      if (!mismatch_seen) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
